// ===== rtl/tsrg_pkg.sv =====
// Shared types and constants of the trapezoid step ramp generator.
`default_nettype none
package tsrg_pkg;

  typedef enum logic [1:0] {
    KIND_MOVE = 2'd0,
    KIND_SLOT = 2'd1,
    KIND_STOP = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  localparam logic [1:0] REG_TOP_SPEED = 2'd0;
  localparam logic [1:0] REG_ACCEL     = 2'd1;
  localparam logic [1:0] REG_DECEL     = 2'd2;
  localparam logic [1:0] REG_SPARE     = 2'd3;

  localparam logic [17:0] MIN_SPEED     = 18'd50;
  localparam logic [17:0] SPEED_CEIL    = 18'd160000;
  localparam logic [21:0] ABS_MAX_RATE  = 22'd2666666;
  localparam logic [21:0] DEF_RATE      = 22'd1000000;
  localparam logic [20:0] HALF_MAX      = 21'h1FFFFF;
  localparam logic [30:0] COUNT_MAX     = 31'h7FFFFFFF;

  typedef struct packed {
    logic [17:0] top_speed;
    logic [21:0] accel;
    logic [21:0] decel;
    logic [35:0] max_sq;
  } cfg_t;

  typedef struct packed {
    logic        ack_busy;
    logic        step_valid;
    logic [20:0] half_cycles;
    logic        moving;
    logic        forward;
    logic [25:0] current_speed;
    logic [30:0] steps_left;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/tsrg_alu.sv =====
// Shared adder and subtractor of the ramp sequencer.
`default_nettype none
module tsrg_alu #(
  parameter int W = 54
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic         sub,
  output logic [W-1:0]      res,
  output logic              borrow
);
  logic [W:0] sum;

  assign sum    = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
  assign res    = sum[W-1:0];
  assign borrow = sub & ~sum[W];
endmodule
`default_nettype wire

// ===== rtl/tsrg_core.sv =====
// Move state and the sequencer that works out speed and half period per step.
`default_nettype none
module tsrg_core #(
  parameter int SPEED_FRAC_BITS = 8,
  parameter int STEP_CLOCK_HZ   = 150000000
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [1:0]    kind,
  input  wire logic [31:0]   move_steps,
  input  wire tsrg_pkg::cfg_t cfg,
  input  wire logic          take,
  output logic               idle,
  output logic               res_valid,
  output tsrg_pkg::res_t     res
);
  import tsrg_pkg::*;

  localparam int F   = SPEED_FRAC_BITS;
  localparam int SW  = 18 + F;
  localparam int DW  = 2 * SW + 2;
  localparam int RTW = DW / 2;
  localparam int CW  = $clog2(DW + 1);

  localparam logic [DW-1:0] VMIN_D = DW'(MIN_SPEED) << F;
  localparam logic [DW-1:0] VMINSQ = DW'(64'(MIN_SPEED) * 64'(MIN_SPEED)) << F;
  localparam logic [DW-1:0] HP_NUM = DW'(64'(STEP_CLOCK_HZ) << F);
  localparam logic [DW-1:0] THREE  = DW'(3);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_BRK_SUB, S_BRK_DIV, S_BRK_CMP, S_DEC_SUB, S_DEC_CMP,
    S_ACC_CMP, S_ACC_ADD, S_ACC_LIM, S_ROOT, S_HP_DIV, S_HP_SUB, S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic            busy_r, busy_nxt;
  logic            stop_r, stop_nxt;
  logic            dir_r, dir_nxt;
  logic [SW-1:0]   speed_r, speed_nxt;
  logic [30:0]     count_r, count_nxt;
  logic            ack_r, ack_nxt;
  logic            stepv_r, stepv_nxt;
  logic [20:0]     half_r, half_nxt;
  logic [DW-1:0]   a_r, a_nxt;
  logic [DW-1:0]   b_r, b_nxt;
  logic [DW-1:0]   sq_r, sq_nxt;
  logic [RTW-1:0]  root_r, root_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  logic [DW-1:0]   alu_a, alu_b, alu_res;
  logic            alu_sub, alu_borrow;
  logic [DW-1:0]   v_d, vmax_d, vmax_sq, two_a, two_d, two_v, cm1;
  logic [31:0]     mag;

  assign v_d     = DW'(speed_r);
  assign vmax_d  = DW'(cfg.top_speed) << F;
  assign vmax_sq = DW'(cfg.max_sq) << F;
  assign two_a   = DW'({cfg.accel, 1'b0}) << F;
  assign two_d   = DW'({cfg.decel, 1'b0}) << F;
  assign two_v   = DW'({speed_r, 1'b0});
  assign cm1     = DW'(count_r - 31'd1);
  assign mag     = move_steps[31] ? (~move_steps + 32'd1) : move_steps;

  tsrg_alu #(.W(DW)) u_alu (
    .a(alu_a), .b(alu_b), .sub(alu_sub), .res(alu_res), .borrow(alu_borrow)
  );

  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    stop_nxt  = stop_r;
    dir_nxt   = dir_r;
    speed_nxt = speed_r;
    count_nxt = count_r;
    ack_nxt   = ack_r;
    stepv_nxt = stepv_r;
    half_nxt  = half_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    sq_nxt    = sq_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    alu_a     = a_r;
    alu_b     = b_r;
    alu_sub   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ack_nxt   = 1'b0;
          stepv_nxt = 1'b0;
          half_nxt  = '0;
          state_nxt = S_DONE;
          case (kind_t'(kind))
            KIND_MOVE: begin
              if (busy_r) begin
                ack_nxt = 1'b1;
              end else if (move_steps != 32'd0) begin
                dir_nxt   = ~move_steps[31];
                count_nxt = mag[31] ? COUNT_MAX : mag[30:0];
                speed_nxt = SW'(VMIN_D);
                stop_nxt  = 1'b0;
                busy_nxt  = 1'b1;
              end
            end
            KIND_SLOT: begin
              if (busy_r) begin
                if (stop_r || count_r == 31'd0) begin
                  busy_nxt  = 1'b0;
                  speed_nxt = '0;
                  stop_nxt  = 1'b0;
                end else begin
                  a_nxt     = '0;
                  b_nxt     = v_d;
                  cnt_nxt   = CW'(SW - 1);
                  state_nxt = S_MUL;
                end
              end
            end
            KIND_STOP: begin
              if (busy_r) begin
                stop_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MUL: begin
        // Shift-and-add square, multiplier bits taken from the top.
        alu_a   = a_r << 1;
        alu_b   = b_r[SW-1] ? v_d : '0;
        alu_sub = 1'b0;
        a_nxt   = alu_res;
        b_nxt   = b_r << 1;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          sq_nxt    = alu_res >> F;
          state_nxt = S_BRK_SUB;
        end
      end
      S_BRK_SUB: begin
        alu_a     = sq_r;
        alu_b     = VMINSQ;
        b_nxt     = alu_borrow ? '0 : alu_res;
        a_nxt     = '0;
        cnt_nxt   = CW'(DW - 1);
        state_nxt = S_BRK_DIV;
      end
      S_BRK_DIV, S_HP_DIV: begin
        // Restoring division: remainder in a_r, dividend shifts out of b_r
        // while the quotient shifts in.
        alu_a   = {a_r[DW-2:0], b_r[DW-1]};
        alu_b   = (state_r == S_BRK_DIV) ? two_d : two_v;
        a_nxt   = alu_borrow ? alu_a : alu_res;
        b_nxt   = {b_r[DW-2:0], ~alu_borrow};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = (state_r == S_BRK_DIV) ? S_BRK_CMP : S_HP_SUB;
        end
      end
      S_BRK_CMP: begin
        // Brake once the steps left, less one, fit in the braking distance.
        alu_a     = b_r;
        alu_b     = cm1;
        state_nxt = alu_borrow ? S_ACC_CMP : S_DEC_SUB;
      end
      S_DEC_SUB: begin
        alu_a = sq_r;
        alu_b = two_d;
        b_nxt = alu_res;
        if (alu_borrow) begin
          speed_nxt = SW'(VMIN_D);
          a_nxt     = '0;
          b_nxt     = HP_NUM;
          cnt_nxt   = CW'(DW - 1);
          state_nxt = S_HP_DIV;
        end else begin
          state_nxt = S_DEC_CMP;
        end
      end
      S_DEC_CMP, S_ACC_LIM: begin
        alu_a = (state_r == S_DEC_CMP) ? VMINSQ : b_r;
        alu_b = (state_r == S_DEC_CMP) ? b_r : vmax_sq;
        if (alu_borrow) begin
          a_nxt     = '0;
          b_nxt     = b_r << F;
          root_nxt  = '0;
          cnt_nxt   = CW'(RTW - 1);
          state_nxt = S_ROOT;
        end else begin
          speed_nxt = (state_r == S_DEC_CMP) ? SW'(VMIN_D) : SW'(vmax_d);
          a_nxt     = '0;
          b_nxt     = HP_NUM;
          cnt_nxt   = CW'(DW - 1);
          state_nxt = S_HP_DIV;
        end
      end
      S_ACC_CMP: begin
        alu_a = v_d;
        alu_b = vmax_d;
        if (alu_borrow) begin
          state_nxt = S_ACC_ADD;
        end else begin
          speed_nxt = SW'(vmax_d);
          a_nxt     = '0;
          b_nxt     = HP_NUM;
          cnt_nxt   = CW'(DW - 1);
          state_nxt = S_HP_DIV;
        end
      end
      S_ACC_ADD: begin
        alu_a     = sq_r;
        alu_b     = two_a;
        alu_sub   = 1'b0;
        b_nxt     = alu_res;
        state_nxt = S_ACC_LIM;
      end
      S_ROOT: begin
        // Digit-by-digit square root, two radicand bits per cycle.
        alu_a    = {a_r[DW-3:0], b_r[DW-1:DW-2]};
        alu_b    = DW'({root_r, 2'b01});
        a_nxt    = alu_borrow ? alu_a : alu_res;
        b_nxt    = b_r << 2;
        root_nxt = {root_r[RTW-2:0], ~alu_borrow};
        cnt_nxt  = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          speed_nxt = SW'(root_nxt);
          a_nxt     = '0;
          b_nxt     = HP_NUM;
          cnt_nxt   = CW'(DW - 1);
          state_nxt = S_HP_DIV;
        end
      end
      S_HP_SUB: begin
        alu_a     = b_r;
        alu_b     = THREE;
        if (alu_borrow) begin
          half_nxt = '0;
        end else if (|alu_res[DW-1:21]) begin
          half_nxt = HALF_MAX;
        end else begin
          half_nxt = alu_res[20:0];
        end
        stepv_nxt = 1'b1;
        count_nxt = count_r - 31'd1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      stop_r  <= 1'b0;
      dir_r   <= 1'b1;
      speed_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      stop_r  <= stop_nxt;
      dir_r   <= dir_nxt;
      speed_r <= speed_nxt;
      count_r <= count_nxt;
    end
    ack_r   <= ack_nxt;
    stepv_r <= stepv_nxt;
    half_r  <= half_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    sq_r    <= sq_nxt;
    root_r  <= root_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res.ack_busy      = ack_r;
    res.step_valid    = stepv_r;
    res.half_cycles   = half_r;
    res.moving        = busy_r;
    res.forward       = dir_r;
    res.current_speed = 26'(speed_r);
    res.steps_left    = count_r;
  end
endmodule
`default_nettype wire

// ===== rtl/trapezoid_step_ramp_generator_unit.sv =====
// Top level of the trapezoid step ramp generator: handshakes and settings.
//
// Takes move, step slot and stop items and answers each with one result item.
// Moves, stops and idle slots are answered without the sequencer. A step slot
// during a move with steps left and no stop pending runs a sequencer around
// one shared adder: a shift-add square of the speed, a restoring division for
// the braking distance, a digit-by-digit square root for the new speed where
// needed and a restoring division for the half period; otherwise the slot
// ends the move. The input is not ready while an item is in work; a finished
// result waits in the output register, so the next item may be taken meanwhile.
`default_nettype none
module trapezoid_step_ramp_generator_unit #(
  parameter int SPEED_FRAC_BITS = 8,
  parameter int STEP_CLOCK_HZ   = 150000000
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // move_steps
  input  wire logic [1:0]  in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // ack_busy, step_valid, half_cycles, moving,
                                       // forward, current_speed, steps_left
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [21:0] cfg_wdata
);
  import tsrg_pkg::*;

  logic [17:0] max_r, max_nxt;
  logic [21:0] accel_r, accel_nxt;
  logic [21:0] decel_r, decel_nxt;
  logic [35:0] max_sq_r;
  cfg_t        cfg;
  logic        core_idle, res_valid, take, start;
  res_t        res;
  logic        out_valid_r;
  logic [87:0] out_data_r;

  always_comb begin
    max_nxt   = max_r;
    accel_nxt = accel_r;
    decel_nxt = decel_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_TOP_SPEED: begin
          if (cfg_wdata[17:0] < MIN_SPEED) begin
            max_nxt = MIN_SPEED;
          end else if (cfg_wdata[17:0] > SPEED_CEIL) begin
            max_nxt = SPEED_CEIL;
          end else begin
            max_nxt = cfg_wdata[17:0];
          end
        end
        REG_ACCEL: begin
          accel_nxt = (cfg_wdata == '0 || cfg_wdata > ABS_MAX_RATE) ? DEF_RATE : cfg_wdata;
        end
        REG_DECEL: begin
          decel_nxt = (cfg_wdata == '0 || cfg_wdata > ABS_MAX_RATE) ? DEF_RATE : cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= SPEED_CEIL;
      accel_r     <= DEF_RATE;
      decel_r     <= DEF_RATE;
      out_valid_r <= 1'b0;
    end else begin
      max_r   <= max_nxt;
      accel_r <= accel_nxt;
      decel_r <= decel_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    // Settings are to change only while idle (the block does not enforce it), so the square has long settled.
    max_sq_r <= {18'd0, max_r} * {18'd0, max_r};
    if (take) begin
      out_data_r <= {6'd0, res.steps_left, res.current_speed, res.forward, res.moving,
                     res.half_cycles, res.step_valid, res.ack_busy};
    end
  end

  always_comb begin
    cfg.top_speed = max_r;
    cfg.accel     = accel_r;
    cfg.decel     = decel_r;
    cfg.max_sq    = max_sq_r;
  end

  assign take      = res_valid & (~out_valid_r | out_tready);
  assign in_tready = core_idle;
  assign start     = in_tvalid & core_idle;

  tsrg_core #(
    .SPEED_FRAC_BITS(SPEED_FRAC_BITS),
    .STEP_CLOCK_HZ  (STEP_CLOCK_HZ)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .kind      (in_tuser),
    .move_steps(in_tdata),
    .cfg       (cfg),
    .take      (take),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
endmodule
`default_nettype wire

// ===== rtl/tsrg_checker.sv =====
// Port-level checks of the ramp generator, bound to its top level.
`default_nettype none
module tsrg_sva (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata
);
  // A stalled result item holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // An accepted input item keeps the input busy for at least the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready straight after an accepted item");

  // A step is only issued during a move.
  a_step_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[23])
    else $error("step issued while not moving");

  // Outside a move the speed reads zero.
  a_idle_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[23] |-> out_tdata[50:25] == 26'd0)
    else $error("speed nonzero while idle");

  // A refused move never carries a step.
  a_ack_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[1] && out_tdata[23])
    else $error("refused move with step or while idle");
endmodule

bind trapezoid_step_ramp_generator_unit tsrg_sva u_tsrg_checker (.*);
`default_nettype wire
